FILE: rtl/sms_pkg.sv
// Shared types, codes and reset constants for the satellite mode sequencer.
`default_nettype none

package sms_pkg;

   localparam int unsigned COUNT_W    = 16;
   localparam int unsigned CSR_IDX_W  = 4;
   localparam int unsigned RSP_DATA_W = 8;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] REG_SILENCE_TICKS  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DETUMBLE_TICKS = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RADEX_TIMEOUT  = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_TRX_TIMEOUT    = 4'd3;

   localparam logic [COUNT_W-1:0] SILENCE_TICKS_RST  = 16'd1800;
   localparam logic [COUNT_W-1:0] DETUMBLE_TICKS_RST = 16'd600;
   localparam logic [COUNT_W-1:0] RADEX_TIMEOUT_RST  = 16'd600;
   localparam logic [COUNT_W-1:0] TRX_TIMEOUT_RST    = 16'd600;

   typedef enum logic [2:0] {
      ACT_TICK          = 3'd0,
      ACT_DETACH        = 3'd1,
      ACT_SILENCE_DONE  = 3'd2,
      ACT_DETUMBLE_DONE = 3'd3,
      ACT_BEACON        = 3'd4,
      ACT_SCHED_RADEX   = 3'd5,
      ACT_TRX_DONE      = 3'd6,
      ACT_RADEX_DONE    = 3'd7
   } action_type;

   // flight mode, held one-hot
   typedef enum logic [6:0] {
      MODE_RECOVER  = 7'b0000001,
      MODE_INVEC    = 7'b0000010,
      MODE_SILENCE  = 7'b0000100,
      MODE_DETUMBLE = 7'b0001000,
      MODE_NOMINAL  = 7'b0010000,
      MODE_TRX      = 7'b0100000,
      MODE_RADEX    = 7'b1000000
   } mode_type;

   localparam logic [2:0] CODE_RECOVER  = 3'd0;
   localparam logic [2:0] CODE_INVEC    = 3'd1;
   localparam logic [2:0] CODE_SILENCE  = 3'd2;
   localparam logic [2:0] CODE_DETUMBLE = 3'd3;
   localparam logic [2:0] CODE_NOMINAL  = 3'd4;
   localparam logic [2:0] CODE_TRX      = 3'd5;
   localparam logic [2:0] CODE_RADEX    = 3'd6;

   typedef struct packed {
      action_type         kind;
      logic [COUNT_W-1:0] delay;
   } cmd_type;

   function automatic logic [2:0] mode_code(input mode_type m);
      logic [2:0] c;
      case (m)
         MODE_RECOVER:  c = CODE_RECOVER;
         MODE_INVEC:    c = CODE_INVEC;
         MODE_SILENCE:  c = CODE_SILENCE;
         MODE_DETUMBLE: c = CODE_DETUMBLE;
         MODE_NOMINAL:  c = CODE_NOMINAL;
         MODE_TRX:      c = CODE_TRX;
         MODE_RADEX:    c = CODE_RADEX;
         default:       c = CODE_RECOVER;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/sms_front.sv
// Front end: takes request transactions, decodes them and queues commands.
`default_nettype none

module sms_front
   import sms_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic [COUNT_W-1:0] req_tdata,   // [15:0] radex_delay
   input  wire logic [2:0]         req_tuser,   // [2:0] action
   output logic                    q_valid,
   output cmd_type                 q_cmd,
   input  wire logic               q_pop
);

   cmd_type    q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   cmd_type    cmd_dec;

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (count_ff != 2'd0);
   assign q_cmd      = q_ff[rd_ptr_ff];

   // delay only matters for a radex schedule; keep it clear otherwise
   always_comb begin
      cmd_dec.kind  = action_type'(req_tuser);
      cmd_dec.delay = (action_type'(req_tuser) == ACT_SCHED_RADEX) ? req_tdata : '0;
   end

   always_comb begin
      wr_ptr_in = push  ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !q_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd_dec;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("queue count out of range");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> count_ff != 2'd0)
      else $error("pop from empty queue");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 || count_ff == 2'd2) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

FILE: rtl/sms_exec.sv
// Back end: mode sequencer state, config registers and response register.
`default_nettype none

module sms_exec
   import sms_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  q_valid,
   input  wire cmd_type               q_cmd,
   output logic                       q_pop,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [COUNT_W-1:0]    csr_wdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata
);

   logic [COUNT_W-1:0] radex_timeout_ticks_ff, trx_timeout_ticks_ff;

   mode_type           mode_ff, mode_in;
   logic [COUNT_W-1:0] silence_cnt_ff, silence_cnt_in;
   logic [COUNT_W-1:0] detumble_cnt_ff, detumble_cnt_in;
   logic [COUNT_W-1:0] radex_wait_ff, radex_wait_in;
   logic [COUNT_W-1:0] radex_to_ff, radex_to_in;
   logic [COUNT_W-1:0] trx_to_ff, trx_to_in;
   logic detached_ff, detached_in;
   logic beacon_ff, beacon_in;
   logic radex_pend_ff, radex_pend_in;
   logic radex_done_ff, radex_done_in;
   logic trx_done_ff, trx_done_in;
   logic watchdog_ff, watchdog_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   assign q_pop      = q_valid && (!rsp_valid_ff || rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      mode_in         = mode_ff;
      silence_cnt_in  = silence_cnt_ff;
      detumble_cnt_in = detumble_cnt_ff;
      radex_wait_in   = radex_wait_ff;
      radex_to_in     = radex_to_ff;
      trx_to_in       = trx_to_ff;
      detached_in     = detached_ff;
      beacon_in       = beacon_ff;
      radex_pend_in   = radex_pend_ff;
      radex_done_in   = radex_done_ff;
      trx_done_in     = trx_done_ff;
      watchdog_in     = watchdog_ff;

      if (q_pop) begin
         case (q_cmd.kind)
            ACT_TICK: begin
               // mode blocks run in order, each seeing the mode left before it
               if (mode_in == MODE_RECOVER) begin
                  if (!detached_in)                mode_in = MODE_INVEC;
                  else if (silence_cnt_in != '0)   mode_in = MODE_SILENCE;
                  else if (detumble_cnt_in != '0)  mode_in = MODE_DETUMBLE;
                  else                             mode_in = MODE_NOMINAL;
               end
               if (mode_in == MODE_INVEC && detached_in) begin
                  mode_in = MODE_SILENCE;
               end
               if (mode_in == MODE_SILENCE) begin
                  if (silence_cnt_in != '0) silence_cnt_in = silence_cnt_in - 16'd1;
                  else                      mode_in = MODE_DETUMBLE;
               end
               if (mode_in == MODE_DETUMBLE) begin
                  if (detumble_cnt_in != '0) detumble_cnt_in = detumble_cnt_in - 16'd1;
                  else                       mode_in = MODE_NOMINAL;
               end
               if (mode_in == MODE_NOMINAL) begin
                  if (radex_pend_in && radex_wait_in != '0) begin
                     radex_wait_in = radex_wait_in - 16'd1;
                  end
                  if (radex_pend_in && radex_wait_in == '0) begin
                     mode_in     = MODE_RADEX;
                     radex_to_in = radex_timeout_ticks_ff;
                  end
                  if (beacon_in) begin
                     mode_in   = MODE_TRX;
                     beacon_in = 1'b0;
                     trx_to_in = trx_timeout_ticks_ff;
                  end
               end
               if (mode_in == MODE_TRX) begin
                  watchdog_in = 1'b1;
                  if (trx_done_in || trx_to_in == '0) begin
                     mode_in     = MODE_NOMINAL;
                     watchdog_in = 1'b0;
                  end else begin
                     trx_to_in = trx_to_in - 16'd1;
                  end
               end
               if (mode_in == MODE_RADEX) begin
                  if (radex_done_in || radex_to_in == '0) begin
                     mode_in       = MODE_NOMINAL;
                     radex_pend_in = 1'b0;
                  end else begin
                     radex_to_in = radex_to_in - 16'd1;
                  end
               end
            end
            ACT_DETACH:        detached_in     = 1'b1;
            ACT_SILENCE_DONE:  silence_cnt_in  = '0;
            ACT_DETUMBLE_DONE: detumble_cnt_in = '0;
            ACT_BEACON: begin
               beacon_in   = 1'b1;
               trx_done_in = 1'b0;
               trx_to_in   = trx_timeout_ticks_ff;
               mode_in     = MODE_TRX;
            end
            ACT_SCHED_RADEX: begin
               radex_wait_in = q_cmd.delay;
               radex_pend_in = 1'b1;
               radex_done_in = 1'b0;
            end
            ACT_TRX_DONE:      trx_done_in   = 1'b1;
            ACT_RADEX_DONE:    radex_done_in = 1'b1;
            default: ;
         endcase
      end

      // csr writes must come only while idle (unenforced); these set counters
      if (csr_we && csr_index == REG_SILENCE_TICKS) begin
         silence_cnt_in = csr_wdata;
      end
      if (csr_we && csr_index == REG_DETUMBLE_TICKS) begin
         detumble_cnt_in = csr_wdata;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (q_pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      rsp_data_in = {4'b0000, watchdog_in, mode_code(mode_in)};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radex_timeout_ticks_ff <= RADEX_TIMEOUT_RST;
         trx_timeout_ticks_ff   <= TRX_TIMEOUT_RST;
         mode_ff                <= MODE_RECOVER;
         silence_cnt_ff         <= SILENCE_TICKS_RST;
         detumble_cnt_ff        <= DETUMBLE_TICKS_RST;
         radex_wait_ff          <= '0;
         radex_to_ff            <= RADEX_TIMEOUT_RST;
         trx_to_ff              <= TRX_TIMEOUT_RST;
         detached_ff            <= 1'b0;
         beacon_ff              <= 1'b0;
         radex_pend_ff          <= 1'b0;
         radex_done_ff          <= 1'b0;
         trx_done_ff            <= 1'b0;
         watchdog_ff            <= 1'b0;
         rsp_valid_ff           <= 1'b0;
      end else begin
         mode_ff         <= mode_in;
         silence_cnt_ff  <= silence_cnt_in;
         detumble_cnt_ff <= detumble_cnt_in;
         radex_wait_ff   <= radex_wait_in;
         radex_to_ff     <= radex_to_in;
         trx_to_ff       <= trx_to_in;
         detached_ff     <= detached_in;
         beacon_ff       <= beacon_in;
         radex_pend_ff   <= radex_pend_in;
         radex_done_ff   <= radex_done_in;
         trx_done_ff     <= trx_done_in;
         watchdog_ff     <= watchdog_in;
         rsp_valid_ff    <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               REG_RADEX_TIMEOUT: radex_timeout_ticks_ff <= csr_wdata;
               REG_TRX_TIMEOUT:   trx_timeout_ticks_ff   <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   a_wd_in_trx: assert property (@(posedge clock) disable iff (reset)
      watchdog_ff |-> mode_ff == MODE_TRX)
      else $error("watchdog on outside transmission mode");

   a_beacon_trx: assert property (@(posedge clock) disable iff (reset)
      (q_pop && q_cmd.kind == ACT_BEACON) |=> mode_ff == MODE_TRX && beacon_ff)
      else $error("beacon did not force transmission mode");

   a_detach_sticky: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> !$fell(detached_ff))
      else $error("detached flag cleared without reset");

   a_rsp_matches_state: assert property (@(posedge clock) disable iff (reset)
      $past(q_pop) |-> rsp_valid_ff && rsp_data_ff[3] == watchdog_ff
                       && rsp_data_ff[2:0] == mode_code(mode_ff))
      else $error("response does not reflect executed state");

endmodule

`default_nettype wire

FILE: rtl/satellite_mode_sequencer.sv
// Top level of the satellite mode sequencer: front end, command queue, back end.
//
// Usage:
//   req_*  : one transaction per tick or event. req_tuser carries the action code
//            (0 tick, 1 detach, 2 silence done, 3 detumble done, 4 beacon,
//            5 schedule radex, 6 trx finished, 7 radex finished), req_tdata the
//            radex delay in ticks, read only with a radex schedule.
//   rsp_*  : exactly one transaction per request, in order: mode code in
//            rsp_tdata[2:0], transmission watchdog enable in rsp_tdata[3].
//   csr_*  : write-only registers 0..3 (silence, detumble, radex time-out,
//            trx time-out, in ticks); indexes above three are ignored. Write
//            only while no request is in flight.
// A request is first written into the command queue; its response is registered when
// the back end pops it. One request per cycle is sustained while rsp_tready stays high;
// a tick is evaluated in full in the back end as it leaves the queue.
// A two-entry command queue lets the front keep taking requests while a
// response waits; when rsp_tready stays low the queue fills and req_tready
// drops once both entries are full. Synchronous reset empties the queue, puts
// the block in recover mode and restores the register defaults.
`default_nettype none

module satellite_mode_sequencer
   import sms_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [COUNT_W-1:0]    req_tdata,   // [15:0] radex_delay
   input  wire logic [2:0]            req_tuser,   // [2:0] action
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,   // [2:0] mode, [3] watchdog_enable
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [COUNT_W-1:0]    csr_wdata
);

   logic    q_valid;
   logic    q_pop;
   cmd_type q_cmd;

   sms_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_cmd      (q_cmd),
      .q_pop      (q_pop)
   );

   sms_exec u_exec (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_cmd      (q_cmd),
      .q_pop      (q_pop),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

FILE: sim/tb.sv
// Self-checking testbench for satellite_mode_sequencer: directed mission runs, then random traffic.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sms_pkg::*;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [COUNT_W-1:0]    req_tdata;   // [15:0] radex_delay
   logic [2:0]            req_tuser;   // [2:0] action
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // [2:0] mode, [3] watchdog_enable
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [COUNT_W-1:0]    csr_wdata;

   satellite_mode_sequencer dut (.*);

   typedef struct packed {
      logic       watchdog;
      logic [2:0] mode;
   } mode_report_type;

   mode_report_type mode_reports[$];
   int unsigned     mismatches;
   bit              no_gaps;

   // flight state as predicted
   logic [2:0]         fl_mode;
   logic [COUNT_W-1:0] silence_left, detumble_left, radex_wait_left, radex_left, trx_left;
   bit                 is_detached, beacon_armed, radex_pending, radex_done, trx_done;
   bit                 watchdog_on;
   logic [COUNT_W-1:0] cfg_radex_to, cfg_trx_to;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void note_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("tb: %s", msg);
   endfunction

   // mode blocks run in fixed order, each seeing the mode left by the one before
   function automatic void advance_tick();
      if (fl_mode == CODE_RECOVER) begin
         if (!is_detached) fl_mode = CODE_INVEC;
         else if (silence_left != 0) fl_mode = CODE_SILENCE;
         else if (detumble_left != 0) fl_mode = CODE_DETUMBLE;
         else fl_mode = CODE_NOMINAL;
      end
      if (fl_mode == CODE_INVEC && is_detached) fl_mode = CODE_SILENCE;
      if (fl_mode == CODE_SILENCE) begin
         if (silence_left != 0) silence_left--;
         else fl_mode = CODE_DETUMBLE;
      end
      if (fl_mode == CODE_DETUMBLE) begin
         if (detumble_left != 0) detumble_left--;
         else fl_mode = CODE_NOMINAL;
      end
      if (fl_mode == CODE_NOMINAL) begin
         if (radex_pending && radex_wait_left != 0) radex_wait_left--;
         if (radex_pending && radex_wait_left == 0) begin
            fl_mode    = CODE_RADEX;
            radex_left = cfg_radex_to;
         end
         // beacon wins over a radex start in the same tick
         if (beacon_armed) begin
            fl_mode      = CODE_TRX;
            beacon_armed = 1'b0;
            trx_left     = cfg_trx_to;
         end
      end
      if (fl_mode == CODE_TRX) begin
         watchdog_on = 1'b1;
         if (trx_done || trx_left == 0) begin
            fl_mode     = CODE_NOMINAL;
            watchdog_on = 1'b0;
         end else begin
            trx_left--;
         end
      end
      if (fl_mode == CODE_RADEX) begin
         if (radex_done || radex_left == 0) begin
            fl_mode       = CODE_NOMINAL;
            radex_pending = 1'b0;
         end else begin
            radex_left--;
         end
      end
   endfunction

   function automatic void predict_report(input action_type act, input logic [COUNT_W-1:0] dly);
      mode_report_type rep;
      case (act)
         ACT_TICK:          advance_tick();
         ACT_DETACH:        is_detached = 1'b1;
         ACT_SILENCE_DONE:  silence_left = '0;
         ACT_DETUMBLE_DONE: detumble_left = '0;
         ACT_BEACON: begin
            beacon_armed = 1'b1;
            trx_done     = 1'b0;
            trx_left     = cfg_trx_to;
            fl_mode      = CODE_TRX;
         end
         ACT_SCHED_RADEX: begin
            radex_wait_left = dly;
            radex_pending   = 1'b1;
            radex_done      = 1'b0;
         end
         ACT_TRX_DONE:      trx_done = 1'b1;
         default:           radex_done = 1'b1;
      endcase
      rep.mode     = fl_mode;
      rep.watchdog = watchdog_on;
      mode_reports.push_back(rep);
   endfunction

   task automatic send_cmd(input action_type act, input logic [COUNT_W-1:0] dly);
      int unsigned gap;
      gap = no_gaps ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= dly;
      predict_report(act, dly);
      do @(posedge clock); while (req_tready !== 1'b1);
   endtask

   // block must be quiet before any register write
   task automatic wait_idle();
      int unsigned spins;
      req_tvalid <= 1'b0;
      spins = 0;
      while (mode_reports.size() != 0 && spins < 2000) begin
         @(posedge clock);
         spins++;
      end
      repeat (4) @(posedge clock);
   endtask

   // stray write goes last, so a misdecoded index would clobber a live register
   task automatic write_settings(input logic [COUNT_W-1:0] sil, input logic [COUNT_W-1:0] det,
                                 input logic [COUNT_W-1:0] rad, input logic [COUNT_W-1:0] trx,
                                 input bit stray);
      logic [CSR_IDX_W-1:0] idx [5];
      logic [COUNT_W-1:0]   val [5];
      int unsigned          n;
      idx = '{REG_SILENCE_TICKS, REG_DETUMBLE_TICKS, REG_RADEX_TIMEOUT, REG_TRX_TIMEOUT,
              REG_TRX_TIMEOUT};
      val = '{sil, det, rad, trx, COUNT_W'($urandom)};
      if (stray)
         idx[4] = CSR_IDX_W'($urandom_range(REG_TRX_TIMEOUT + 1, (1 << CSR_IDX_W) - 1));
      n = stray ? 5 : 4;
      for (int i = 0; i < n; i++) begin
         csr_we    <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         @(posedge clock);
         case (idx[i])
            REG_SILENCE_TICKS:  silence_left  = val[i];
            REG_DETUMBLE_TICKS: detumble_left = val[i];
            REG_RADEX_TIMEOUT:  cfg_radex_to  = val[i];
            REG_TRX_TIMEOUT:    cfg_trx_to    = val[i];
            default: ;
         endcase
      end
      csr_we <= 1'b0;
   endtask

   // recover -> in vector -> silence -> detumble -> nominal, silence and detumble ended by done events
   task automatic test_launch_sequence();
      send_cmd(ACT_TICK, '0);
      send_cmd(ACT_DETACH, '0);
      send_cmd(ACT_TICK, '0);
      send_cmd(ACT_SILENCE_DONE, '0);
      send_cmd(ACT_TICK, '0);
      send_cmd(ACT_TICK, '0);
      send_cmd(ACT_DETUMBLE_DONE, '0);
      send_cmd(ACT_TICK, '0);
   endtask

   // zero timeouts: transmission and radex drop straight back to nominal
   task automatic test_register_extremes();
      wait_idle();
      write_settings('1, '0, '0, '0, 1'b1);
      send_cmd(ACT_BEACON, '1);
      send_cmd(ACT_TICK, '0);
      send_cmd(ACT_TICK, '0);
      send_cmd(ACT_SCHED_RADEX, '0);
      send_cmd(ACT_TICK, '0);
   endtask

   task automatic test_mission_events();
      wait_idle();
      write_settings(16'd1, 16'd1, 16'd2, 16'd3, 1'b0);
      send_cmd(ACT_SCHED_RADEX, 16'd1);
      send_cmd(ACT_TICK, '0);
      send_cmd(ACT_TICK, '0);
      send_cmd(ACT_RADEX_DONE, '0);
      send_cmd(ACT_TICK, '0);
      send_cmd(ACT_BEACON, '0);
      send_cmd(ACT_TICK, '0);
      send_cmd(ACT_TRX_DONE, '0);
      // beacon clears a pending trx finished and reloads the time-out
      send_cmd(ACT_BEACON, '0);
      send_cmd(ACT_TICK, '0);
      send_cmd(ACT_TRX_DONE, '0);
      send_cmd(ACT_TICK, '0);
      send_cmd(ACT_SCHED_RADEX, '1);
      send_cmd(ACT_TICK, '0);
   endtask

   task automatic test_random_traffic();
      action_type         act;
      logic [COUNT_W-1:0] dly;
      int unsigned        pick;
      for (int p = 0; p < 8; p++) begin
         wait_idle();
         case (p)
            0: write_settings('0, '0, '0, '0, 1'b1);
            1: write_settings('1, '1, '1, '1, 1'b1);
            2: write_settings(COUNT_W'($urandom), COUNT_W'($urandom), COUNT_W'($urandom),
                              COUNT_W'($urandom), 1'b1);
            default: write_settings(COUNT_W'($urandom_range(0, 6)), COUNT_W'($urandom_range(0, 6)),
                                    COUNT_W'($urandom_range(0, 6)), COUNT_W'($urandom_range(0, 6)),
                                    1'b1);
         endcase
         for (int n = 0; n < 140; n++) begin
            if (n % 32 == 0) no_gaps = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            dly  = ($urandom_range(0, 7) == 0) ? COUNT_W'($urandom)
                                               : COUNT_W'($urandom_range(0, 7));
            if (pick < 50) act = ACT_TICK;
            else if (pick < 60) act = ACT_SCHED_RADEX;
            else if (pick < 68) act = ACT_BEACON;
            else if (pick < 78) act = ACT_TRX_DONE;
            else if (pick < 88) act = ACT_RADEX_DONE;
            else act = action_type'($urandom_range(ACT_DETACH, ACT_DETUMBLE_DONE));
            send_cmd(act, dly);
         end
      end
      no_gaps = 1'b0;
   endtask

   // response side: random stall per transaction, checks against oldest prediction
   initial begin : rsp_sink
      int unsigned     stall;
      mode_report_type want;
      forever begin
         stall = no_gaps ? 0 : $urandom_range(0, 5);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid === 1'b1 && reset === 1'b0));
         if (mode_reports.size() == 0) begin
            note_mismatch($sformatf("unexpected response, data %0h", rsp_tdata));
         end else begin
            want = mode_reports.pop_front();
            if (rsp_tdata[2:0] !== want.mode)
               note_mismatch($sformatf("mode mismatch, expected %0d, got %0d",
                                       want.mode, rsp_tdata[2:0]));
            if (rsp_tdata[3] !== want.watchdog)
               note_mismatch($sformatf("watchdog mismatch, expected %0b, got %0b",
                                       want.watchdog, rsp_tdata[3]));
         end
      end
   end

   initial begin : main_seq
      mismatches      = 0;
      no_gaps         = 1'b0;
      cfg_radex_to    = RADEX_TIMEOUT_RST;
      cfg_trx_to      = TRX_TIMEOUT_RST;
      fl_mode         = CODE_RECOVER;
      silence_left    = SILENCE_TICKS_RST;
      detumble_left   = DETUMBLE_TICKS_RST;
      radex_wait_left = '0;
      radex_left      = RADEX_TIMEOUT_RST;
      trx_left        = TRX_TIMEOUT_RST;
      is_detached     = 1'b0;
      beacon_armed    = 1'b0;
      radex_pending   = 1'b0;
      radex_done      = 1'b0;
      trx_done        = 1'b0;
      watchdog_on     = 1'b0;

      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= ACT_TICK;
      csr_we     <= 1'b0;
      csr_index  <= REG_SILENCE_TICKS;
      csr_wdata  <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_launch_sequence();
      test_register_extremes();
      test_mission_events();
      test_random_traffic();

      wait_idle();
      if (mode_reports.size() != 0)
         note_mismatch($sformatf("%0d responses never arrived", mode_reports.size()));
      if (mismatches == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

   // time limit for the whole run; reaching it ends the test as a failure
   initial begin : watchdog_timer
      #2_000_000;
      $display("tb: FAIL");
      $finish;
   end

endmodule

FILE: files.f
rtl/sms_pkg.sv
rtl/sms_front.sv
rtl/sms_exec.sv
rtl/satellite_mode_sequencer.sv
sim/tb.sv
